[design/bgq_pkg.sv]
// Shared constants and types for the button gesture qualifier.
`timescale 1ns / 1ps

package bgq_pkg;

    // Field and register widths
    localparam int FIELD_W   = 20;
    localparam int CNT_W     = 16;
    localparam int DLY_W     = 8;
    localparam int WIN_W     = 5;
    localparam int AGO_W     = 6;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register map, by word index
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_WINDOW    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAP_WINDOW      = 2'd3;

    // Register reset values
    localparam logic [DLY_W-1:0] RST_REPEAT_DELAY    = 8'd20;
    localparam logic [DLY_W-1:0] RST_REPEAT_INTERVAL = 8'd5;
    localparam logic [WIN_W-1:0] RST_PRESS_WINDOW    = 5'd10;
    localparam logic [WIN_W-1:0] RST_GAP_WINDOW      = 5'd10;

    // History walk starts two frames back; short release looks from three back
    localparam logic [AGO_W-1:0] WALK_FIRST_AGO = 6'd2;
    localparam logic [AGO_W-1:0] SR_FIRST_AGO   = 6'd3;

    // Remainder unit: dividend bits retired per cycle
    localparam int REM_STEP_BITS = 4;
    localparam int REM_STEPS     = CNT_W / REM_STEP_BITS;
    localparam int REM_STEP_W    = $clog2(REM_STEPS);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [DLY_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DLY_W-1:0] rem;
    } rem_rsp_t;

endpackage

[design/button_gesture_qualifier_core.sv]
// Top level: per-frame button gesture qualifier with history walk and shared remainder unit.
// The shared remainder unit serves one button at a time, in lane order.
// The history walk over gap_window+press_window+1 frames, one ring read a cycle, runs
//   alongside; one item at a time, in_stall stays high until the result is registered,
//   so a new frame is taken only after the last one is done; out_stall can delay that.
// rst_n clears control state, hold counters and ring valid bits at once; registers
//   return to their defaults and the ring reads as zeros, with no clearing pass.
`timescale 1ns / 1ps

module button_gesture_qualifier_core #(
    parameter int BUTTONS = 20,
    parameter int HISTORY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgq_pkg::PADDR_W-1:0]   paddr,
    input  logic [bgq_pkg::PDATA_W-1:0]   pwdata,
    output logic [bgq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bgq_pkg::FIELD_W-1:0]   levels,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bgq_pkg::FIELD_W-1:0]   held,
    output logic [bgq_pkg::FIELD_W-1:0]   press_edge,
    output logic [bgq_pkg::FIELD_W-1:0]   release_edge,
    output logic [bgq_pkg::FIELD_W-1:0]   repeat_fire,
    output logic [bgq_pkg::FIELD_W-1:0]   double_press,
    output logic [bgq_pkg::FIELD_W-1:0]   short_release
);
    import bgq_pkg::*;

    localparam int LANES  = (BUTTONS < FIELD_W) ? BUTTONS : FIELD_W;
    localparam int SLOT_W = $clog2(HISTORY);
    localparam int BI_W   = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY - 1);
    localparam logic [BI_W-1:0]   LAST_LANE = BI_W'(LANES - 1);

    // Sequencer states
    localparam int          ST_W   = 2;
    localparam logic [ST_W-1:0] S_IDLE = 2'd0;
    localparam logic [ST_W-1:0] S_RUN  = 2'd1;
    localparam logic [ST_W-1:0] S_DONE = 2'd2;

    // Double press lane states
    localparam logic [1:0] DP_SEEK_HELD = 2'd0;
    localparam logic [1:0] DP_SEEK_GAP  = 2'd1;
    localparam logic [1:0] DP_HIT       = 2'd2;
    localparam logic [1:0] DP_MISS      = 2'd3;

    logic [DLY_W-1:0]  delay_reg;
    logic [DLY_W-1:0]  interval_reg;
    logic [WIN_W-1:0]  pwin_reg;
    logic [WIN_W-1:0]  gwin_reg;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [SLOT_W-1:0] ws_reg;
    logic [SLOT_W-1:0] ws_inc;
    logic [LANES-1:0]  now_in;
    logic [LANES-1:0]  now_reg;
    logic [LANES-1:0]  prev_reg;
    logic [CNT_W-1:0]  hold_cnt_reg [LANES];

    logic [SLOT_W-1:0] rd_idx_reg;
    logic [AGO_W-1:0]  rd_ago_reg;
    logic [AGO_W-1:0]  dago_reg;
    logic              iss_reg;
    logic              dval_reg;
    logic [AGO_W-1:0]  end_ago;
    logic [AGO_W-1:0]  gap_lim;
    logic [AGO_W-1:0]  sr_lim;
    logic [LANES-1:0]  rd_data;

    logic [1:0]        dp_st_reg   [LANES];
    logic [1:0]        dp_st_next  [LANES];
    logic [WIN_W-1:0]  dp_cnt_reg  [LANES];
    logic [WIN_W-1:0]  dp_cnt_next [LANES];
    logic [LANES-1:0]  sr_hit_reg;
    logic [LANES-1:0]  sr_hit_next;

    logic [BI_W-1:0]   bi_reg;
    logic              rem_start_reg;
    logic              rem_fin_reg;
    logic [LANES-1:0]  rep_reg;
    logic              rep_bit;
    rem_req_t          rem_req;
    rem_rsp_t          rem_rsp;

    logic              in_acc;
    logic              out_free;
    logic              finish;
    logic              out_load;
    logic              cfg_wr;

    logic              out_valid_reg;
    logic [FIELD_W-1:0] held_reg, press_reg, release_reg;
    logic [FIELD_W-1:0] repeat_reg, double_reg, short_reg;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= RST_REPEAT_DELAY;
            interval_reg <= RST_REPEAT_INTERVAL;
            pwin_reg     <= RST_PRESS_WINDOW;
            gwin_reg     <= RST_GAP_WINDOW;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_REPEAT_DELAY:    delay_reg    <= pwdata[DLY_W-1:0];
                REG_REPEAT_INTERVAL: interval_reg <= pwdata[DLY_W-1:0];
                REG_PRESS_WINDOW:    pwin_reg     <= pwdata[WIN_W-1:0];
                REG_GAP_WINDOW:      gwin_reg     <= pwdata[WIN_W-1:0];
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_REPEAT_DELAY:    prdata = PDATA_W'(delay_reg);
            REG_REPEAT_INTERVAL: prdata = PDATA_W'(interval_reg);
            REG_PRESS_WINDOW:    prdata = PDATA_W'(pwin_reg);
            REG_GAP_WINDOW:      prdata = PDATA_W'(gwin_reg);
        endcase
    end

    // Handshake and sequencing
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = !iss_reg && !dval_reg && rem_fin_reg;
    assign out_load = out_free && ((state_reg == S_DONE) || ((state_reg == S_RUN) && finish));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (finish)
                begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Ring position and walk bounds
    assign ws_inc  = (ws_reg == LAST_SLOT) ? '0 : ws_reg + 1'b1;
    assign now_in  = levels[LANES-1:0];
    assign end_ago = AGO_W'(gwin_reg) + AGO_W'(pwin_reg) + WALK_FIRST_AGO;
    assign gap_lim = AGO_W'(gwin_reg) + AGO_W'(1);
    assign sr_lim  = AGO_W'(pwin_reg) + WALK_FIRST_AGO;

    bgq_hist #(
        .DEPTH (HISTORY),
        .WIDTH (LANES)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (in_acc),
        .waddr (ws_inc),
        .wdata (now_in),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    // Per-button lookback lanes, fed one past frame a cycle
    always_comb
    begin
        sr_hit_next = sr_hit_reg;
        for (int b = 0; b < LANES; b++)
        begin
            dp_st_next[b]  = dp_st_reg[b];
            dp_cnt_next[b] = dp_cnt_reg[b];
            unique case (dp_st_reg[b])
                DP_SEEK_HELD:
                begin
                    if (dago_reg > gap_lim)
                    begin
                        dp_st_next[b] = DP_MISS;
                    end
                    else if (rd_data[b])
                    begin
                        dp_st_next[b]  = DP_SEEK_GAP;
                        dp_cnt_next[b] = pwin_reg;
                    end
                end
                DP_SEEK_GAP:
                begin
                    if (dp_cnt_reg[b] == '0)
                    begin
                        dp_st_next[b] = DP_MISS;
                    end
                    else if (!rd_data[b])
                    begin
                        dp_st_next[b] = DP_HIT;
                    end
                    else
                    begin
                        dp_cnt_next[b] = dp_cnt_reg[b] - 1'b1;
                    end
                end
                DP_HIT:  dp_st_next[b] = DP_HIT;
                DP_MISS: dp_st_next[b] = DP_MISS;
            endcase
            if (!rd_data[b] && (dago_reg >= SR_FIRST_AGO) && (dago_reg <= sr_lim))
            begin
                sr_hit_next[b] = 1'b1;
            end
        end
    end

    // Repeat decision for the lane whose remainder is ready
    assign rep_bit = now_reg[bi_reg] &&
                     ((hold_cnt_reg[bi_reg] == '0) ||
                      ((hold_cnt_reg[bi_reg] > CNT_W'(delay_reg)) && (rem_rsp.rem == '0)));

    assign rem_req.start    = rem_start_reg;
    assign rem_req.dividend = hold_cnt_reg[bi_reg];
    assign rem_req.divisor  = (interval_reg == '0) ? DLY_W'(1) : interval_reg;

    bgq_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // Control state: frame capture, walk, remainder sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            now_reg       <= '0;
            prev_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_ago_reg    <= '0;
            dago_reg      <= '0;
            iss_reg       <= 1'b0;
            dval_reg      <= 1'b0;
            sr_hit_reg    <= '0;
            bi_reg        <= '0;
            rem_start_reg <= 1'b0;
            rem_fin_reg   <= 1'b0;
            rep_reg       <= '0;
            for (int b = 0; b < LANES; b++)
            begin
                hold_cnt_reg[b] <= '0;
                dp_st_reg[b]    <= DP_MISS;
                dp_cnt_reg[b]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rem_start_reg <= 1'b0;
            if (in_acc)
            begin
                // capture the frame and arm the walk and remainder pass
                ws_reg        <= ws_inc;
                now_reg       <= now_in;
                prev_reg      <= now_reg;
                rd_idx_reg    <= (ws_reg == '0) ? LAST_SLOT : ws_reg - 1'b1;
                rd_ago_reg    <= WALK_FIRST_AGO;
                iss_reg       <= 1'b1;
                dval_reg      <= 1'b0;
                sr_hit_reg    <= '0;
                bi_reg        <= '0;
                rem_start_reg <= 1'b1;
                rem_fin_reg   <= 1'b0;
                rep_reg       <= '0;
                for (int b = 0; b < LANES; b++)
                begin
                    if (now_in[b] && now_reg[b])
                    begin
                        if (hold_cnt_reg[b] != CNT_MAX)
                        begin
                            hold_cnt_reg[b] <= hold_cnt_reg[b] + 1'b1;
                        end
                    end
                    else
                    begin
                        hold_cnt_reg[b] <= '0;
                    end
                    dp_st_reg[b] <= (now_in[b] && !now_reg[b]) ? DP_SEEK_HELD : DP_MISS;
                end
            end
            else if (state_reg == S_RUN)
            begin
                // step the read pointer back one frame
                dval_reg <= iss_reg;
                dago_reg <= rd_ago_reg;
                if (iss_reg)
                begin
                    rd_idx_reg <= (rd_idx_reg == '0) ? LAST_SLOT : rd_idx_reg - 1'b1;
                    rd_ago_reg <= rd_ago_reg + 1'b1;
                    iss_reg    <= (rd_ago_reg != end_ago);
                end
                // advance the lanes on returned data
                if (dval_reg)
                begin
                    sr_hit_reg <= sr_hit_next;
                    for (int b = 0; b < LANES; b++)
                    begin
                        dp_st_reg[b]  <= dp_st_next[b];
                        dp_cnt_reg[b] <= dp_cnt_next[b];
                    end
                end
                // collect a remainder and start the next button
                if (rem_rsp.done)
                begin
                    rep_reg[bi_reg] <= rep_bit;
                    if (bi_reg == LAST_LANE)
                    begin
                        rem_fin_reg <= 1'b1;
                    end
                    else
                    begin
                        bi_reg        <= bi_reg + 1'b1;
                        rem_start_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            held_reg    <= FIELD_W'(now_reg);
            press_reg   <= FIELD_W'(now_reg & ~prev_reg);
            release_reg <= FIELD_W'(prev_reg & ~now_reg);
            repeat_reg  <= FIELD_W'(rep_reg);
            short_reg   <= FIELD_W'(~now_reg & prev_reg & sr_hit_reg);
            for (int b = 0; b < FIELD_W; b++)
            begin
                if (b < LANES)
                begin
                    double_reg[b] <= (dp_st_reg[b] == DP_HIT);
                end
                else
                begin
                    double_reg[b] <= 1'b0;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign held          = held_reg;
    assign press_edge    = press_reg;
    assign release_edge  = release_reg;
    assign repeat_fire   = repeat_reg;
    assign double_press  = double_reg;
    assign short_release = short_reg;

`ifndef SYNTHESIS
    a_acc_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_RUN))
        else $error("accepted frame did not start a run");
    a_rem_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_rsp.done || rem_rsp.busy) |-> (state_reg == S_RUN))
        else $error("remainder unit active outside a run");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!iss_reg && !dval_reg))
        else $error("history walk active while idle");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg <= LAST_SLOT)
        else $error("ring slot out of range");
`endif

endmodule

[design/bgq_hist.sv]
// Level history ring: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module bgq_hist #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_reg;
    logic             rd_vld_reg;

    // Mark entries as written; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    // Write and registered read of the ring
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

[design/bgq_rem.sv]
// Iterative remainder unit: hold count modulo repeat interval, four bits per cycle.
`timescale 1ns / 1ps

module bgq_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  bgq_pkg::rem_req_t req,
    output bgq_pkg::rem_rsp_t rsp
);
    import bgq_pkg::*;

    logic [CNT_W-1:0]      quo_reg, quo_next;
    logic [DLY_W-1:0]      part_reg, part_next;
    logic [DLY_W-1:0]      dvs_reg;
    logic [REM_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Retire several dividend bits by shift and conditional subtract
    always_comb
    begin
        logic [DLY_W:0]   acc;
        logic [CNT_W-1:0] sh;
        acc = {1'b0, part_reg};
        sh  = quo_reg;
        for (int j = 0; j < REM_STEP_BITS; j++)
        begin
            acc = {acc[DLY_W-1:0], sh[CNT_W-1]};
            sh  = {sh[CNT_W-2:0], 1'b0};
            if (acc >= {1'b0, dvs_reg})
            begin
                acc = acc - {1'b0, dvs_reg};
            end
        end
        part_next = acc[DLY_W-1:0];
        quo_next  = sh;
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == REM_STEP_W'(REM_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= req.dividend;
            part_reg <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg  <= quo_next;
            part_reg <= part_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = part_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("remainder unit restarted while busy");
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (part_reg < dvs_reg))
        else $error("remainder not below divisor");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");
`endif

endmodule
